// ----- sv/ramped_bidirectional_motor_pwm_defines.svh -----
// Assertion macros shared by the motor PWM block.
`ifndef RAMPED_BIDIRECTIONAL_MOTOR_PWM_DEFINES_SVH
`define RAMPED_BIDIRECTIONAL_MOTOR_PWM_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define RBMP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("motor pwm check failed");

// Next-cycle implication, checked on clk and held off during rst.
`define RBMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("motor pwm sequence check failed");

`endif

// ----- sv/rbmp_pkg.sv -----
// Types, constants and codes for the ramped bidirectional motor PWM block.
package rbmp_pkg;

  localparam int SPEED_BITS = 12;
  localparam int SPEED_W    = SPEED_BITS + 1;
  localparam int DUTY_W     = 7;
  localparam int PROD_W     = SPEED_W + DUTY_W;
  localparam int QUOT_W     = PROD_W - SPEED_BITS;
  localparam int RELOAD_W   = 23;
  localparam int TICKS_W    = 16;
  localparam int ACCEL_W    = 8;
  localparam int INTERVAL_W = 8;
  localparam int MS_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SPEED_BITS-1:0] SPEED_FULL = {SPEED_BITS{1'b1}};
  localparam logic [DUTY_W-1:0]     DUTY_MAX   = DUTY_W'(100);

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_STEP        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_INTERVAL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_PERCENT = 2'd2;

  localparam logic [ACCEL_W-1:0]    ACCEL_STEP_RST     = 8'd4;
  localparam logic [INTERVAL_W-1:0] UPDATE_INTERVAL_RST = 8'd10;
  localparam logic [TICKS_W-1:0]    TICKS_PER_PCT_RST  = 16'd800;

  localparam logic [1:0] REQ_TIMER   = 2'd0;
  localparam logic [1:0] REQ_START   = 2'd1;
  localparam logic [1:0] REQ_CONTROL = 2'd2;

  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_CW   = 2'd1;
  localparam logic [1:0] KEY_CCW  = 2'd2;
  localparam logic [1:0] KEY_STOP = 2'd3;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [1:0]            key_code;
    logic                  start_direction;
    logic [SPEED_BITS-1:0] speed_sample;
  } in_item_t;

  typedef struct packed {
    logic                  motor_enable;
    logic                  pwm_level;
    logic                  drive_clockwise;
    logic [RELOAD_W-1:0]   reload_ticks;
    logic [SPEED_W-1:0]    current_speed;
    logic [SPEED_BITS-1:0] target_speed;
    logic                  target_clockwise;
    logic [DUTY_W-1:0]     duty_percent;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic prod;
    logic duty;
    logic load_out;
  } ctrl_cmd_t;

endpackage

// ----- sv/rbmp_ctrl.sv -----
// Sequencing state machine for the motor PWM block.
module rbmp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rbmp_pkg::ctrl_cmd_t cmd
);
  import rbmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PROD,
    S_DUTY,
    S_HOLD
  } state_t;

  state_t state;

  assign in_ready     = (state == S_IDLE);
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.prod     = (state == S_PROD);
  assign cmd.duty     = (state == S_DUTY);
  // load the result only once the previous beat has left the output register
  assign cmd.load_out = (state == S_HOLD) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: state <= S_PROD;
        S_PROD: state <= S_DUTY;
        S_DUTY: state <= S_HOLD;
        S_HOLD: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/rbmp_datapath.sv -----
// Motor state, ramp update, duty divider, reload multiplier and result register.
module rbmp_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rbmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbmp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rbmp_pkg::in_item_t                  in_item,
  input  rbmp_pkg::ctrl_cmd_t                 cmd,
  output rbmp_pkg::out_item_t                 out_item
);
  import rbmp_pkg::*;

  logic [ACCEL_W-1:0]    accel_step;
  logic [INTERVAL_W-1:0] update_interval_ms;
  logic [TICKS_W-1:0]    ticks_per_percent;

  in_item_t              item;
  logic                  running, running_next;
  logic                  pwm_high, pwm_high_next;
  logic [MS_W-1:0]       ms_count, ms_count_next;
  logic [SPEED_W-1:0]    speed_now, speed_now_next;
  logic                  dir_now_cw, dir_now_cw_next;
  logic [SPEED_BITS-1:0] speed_goal, speed_goal_next;
  logic                  dir_goal_cw, dir_goal_cw_next;
  logic [RELOAD_W-1:0]   reload, reload_next;
  logic [PROD_W-1:0]     prod;
  logic [DUTY_W-1:0]     duty, duty_next;

  logic [DUTY_W-1:0]     phase_pct;
  logic                  goal_cw;
  logic [SPEED_W-1:0]    sample_ext;
  logic [SPEED_W-1:0]    accel_ext;

  // duty = prod / (2^SPEED_BITS - 1): shift estimate plus one correction
  logic [QUOT_W-1:0]     quot_est;
  logic [QUOT_W-1:0]     quot;
  logic [SPEED_BITS:0]   rem_est;

  always_comb begin
    quot_est = prod[PROD_W-1:SPEED_BITS];
    rem_est  = {1'b0, prod[SPEED_BITS-1:0]}
             + {{(SPEED_BITS + 1 - QUOT_W){1'b0}}, quot_est};
    quot     = quot_est + QUOT_W'(rem_est >= {1'b0, SPEED_FULL});
    if (quot > QUOT_W'(DUTY_MAX)) begin
      duty_next = DUTY_MAX;
    end else begin
      duty_next = quot[DUTY_W-1:0];
    end
  end

  always_comb begin
    running_next     = running;
    pwm_high_next    = pwm_high;
    ms_count_next    = ms_count;
    speed_now_next   = speed_now;
    dir_now_cw_next  = dir_now_cw;
    speed_goal_next  = speed_goal;
    dir_goal_cw_next = dir_goal_cw;
    reload_next      = '0;
    phase_pct        = pwm_high ? (DUTY_MAX - duty) : duty;
    sample_ext       = {1'b0, item.speed_sample};
    accel_ext        = {{(SPEED_W - ACCEL_W){1'b0}}, accel_step};
    goal_cw          = dir_goal_cw;
    if (item.key_code == KEY_CW) begin
      goal_cw = 1'b1;
    end else if (item.key_code == KEY_CCW) begin
      goal_cw = 1'b0;
    end

    case (item.req_type)
      REQ_TIMER: begin
        if (running) begin
          reload_next = RELOAD_W'(ticks_per_percent) * RELOAD_W'(phase_pct);
          if (!pwm_high && (ms_count != {MS_W{1'b1}})) begin
            ms_count_next = ms_count + 1'b1;
          end
          pwm_high_next = !pwm_high;
        end
      end
      REQ_START: begin
        if (!running) begin
          dir_goal_cw_next = item.start_direction;
          dir_now_cw_next  = item.start_direction;
          speed_now_next   = '0;
          speed_goal_next  = item.speed_sample;
          ms_count_next    = '0;
          running_next     = 1'b1;
        end
      end
      REQ_CONTROL: begin
        if (running) begin
          dir_goal_cw_next = goal_cw;
          if (item.key_code == KEY_STOP) begin
            running_next = 1'b0;
          end else begin
            speed_goal_next = item.speed_sample;
            if (ms_count > MS_W'(update_interval_ms)) begin
              ms_count_next = ms_count - MS_W'(update_interval_ms);
              if ((dir_now_cw != goal_cw) || (sample_ext < speed_now)) begin
                if (speed_now >= accel_ext) begin
                  speed_now_next = speed_now - accel_ext;
                end else begin
                  // reflect through zero and take the selected direction
                  speed_now_next  = accel_ext - speed_now;
                  dir_now_cw_next = goal_cw;
                end
              end else if (sample_ext > speed_now) begin
                speed_now_next = speed_now + accel_ext;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_step         <= ACCEL_STEP_RST;
      update_interval_ms <= UPDATE_INTERVAL_RST;
      ticks_per_percent  <= TICKS_PER_PCT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACCEL_STEP:        accel_step         <= cfg_data[ACCEL_W-1:0];
        REG_UPDATE_INTERVAL:   update_interval_ms <= cfg_data[INTERVAL_W-1:0];
        REG_TICKS_PER_PERCENT: ticks_per_percent  <= cfg_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= 1'b0;
      pwm_high    <= 1'b0;
      ms_count    <= '0;
      speed_now   <= '0;
      dir_now_cw  <= 1'b1;
      speed_goal  <= '0;
      dir_goal_cw <= 1'b0;
      duty        <= '0;
    end else begin
      if (cmd.exec) begin
        running     <= running_next;
        pwm_high    <= pwm_high_next;
        ms_count    <= ms_count_next;
        speed_now   <= speed_now_next;
        dir_now_cw  <= dir_now_cw_next;
        speed_goal  <= speed_goal_next;
        dir_goal_cw <= dir_goal_cw_next;
      end
      if (cmd.duty) begin
        duty <= duty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_item;
    end
    if (cmd.exec) begin
      reload <= reload_next;
    end
    if (cmd.prod) begin
      prod <= PROD_W'(speed_now) * PROD_W'(DUTY_MAX);
    end
    if (cmd.load_out) begin
      out_item.motor_enable     <= running;
      out_item.pwm_level        <= pwm_high;
      out_item.drive_clockwise  <= dir_now_cw;
      out_item.reload_ticks     <= reload;
      out_item.current_speed    <= speed_now;
      out_item.target_speed     <= speed_goal;
      out_item.target_clockwise <= dir_goal_cw;
      out_item.duty_percent     <= duty;
    end
  end

endmodule

// ----- sv/ramped_bidirectional_motor_pwm.sv -----
// Top level of the ramped bidirectional motor PWM block.
//
//   port group  role            handshake
//   cfg_*       register write  cfg_we, no wait
//   in_item     request beat    in_valid / in_ready
//   out_item    result beat     out_valid / out_ready
//
// One beat at a time: accept, update, speed*100, duty divide, then the result
// register, in that fixed sequence.
// A new beat is taken while the previous result still waits on out_ready.
// A stalled output holds the sequence in its last step until the slot frees.
// rst is synchronous and returns registers to their defaults and the motor to stop.
`include "ramped_bidirectional_motor_pwm_defines.svh"

module ramped_bidirectional_motor_pwm (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rbmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbmp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  rbmp_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output rbmp_pkg::out_item_t             out_item
);
  import rbmp_pkg::*;

  ctrl_cmd_t cmd;

  rbmp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rbmp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .out_item  (out_item)
  );

  `RBMP_ASSERT_NEXT(a_single_beat_in_flight, in_valid && in_ready, !in_ready)
  `RBMP_ASSERT_IMPL(a_duty_in_range, out_valid, out_item.duty_percent <= DUTY_MAX)
  `RBMP_ASSERT_IMPL(a_no_reload_when_stopped, out_valid && !out_item.motor_enable, out_item.reload_ticks == '0)

endmodule

// ----- tb/ramped_bidirectional_motor_pwm_tb.sv -----
// Self-checking testbench for the ramped bidirectional motor PWM block.
module ramped_bidirectional_motor_pwm_tb;
  import rbmp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int HOLD_CYCLES     = 300;
  localparam int MAX_SHOWN       = 10;
  localparam int BURST_BEATS     = 40;
  localparam int PHASE_BEATS     = 100;

  // Tracks the motor state alongside the block and holds the responses it owes.
  class motor_response_board;
    logic [ACCEL_W-1:0]    accel_step;
    logic [INTERVAL_W-1:0] interval_ms;
    logic [TICKS_W-1:0]    ticks_pct;
    logic                  run_on;
    logic                  pwm_hi;
    logic                  drive_cw;
    logic                  goal_cw;
    logic [MS_W-1:0]       ms_elapsed;
    logic [SPEED_W-1:0]    speed_mag;
    logic [SPEED_BITS-1:0] speed_goal;
    out_item_t             expected_responses[$];
    int                    checked;
    int                    mismatches;
    int                    reflections;
    int                    clamped;

    function new();
      accel_step  = ACCEL_STEP_RST;
      interval_ms = UPDATE_INTERVAL_RST;
      ticks_pct   = TICKS_PER_PCT_RST;
      run_on      = 1'b0;
      pwm_hi      = 1'b0;
      drive_cw    = 1'b1;
      goal_cw     = 1'b0;
      ms_elapsed  = '0;
      speed_mag   = '0;
      speed_goal  = '0;
      checked     = 0;
      mismatches  = 0;
      reflections = 0;
      clamped     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ACCEL_STEP:        accel_step  = val[ACCEL_W-1:0];
        REG_UPDATE_INTERVAL:   interval_ms = val[INTERVAL_W-1:0];
        REG_TICKS_PER_PERCENT: ticks_pct   = val[TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function int duty_now();
      int d;
      d = int'(speed_mag) * 100 / int'(SPEED_FULL);
      return (d > 100) ? 100 : d;
    endfunction

    // One slew update, only once enough milliseconds have piled up.
    function void ramp_speed();
      if (ms_elapsed > interval_ms) begin
        ms_elapsed = ms_elapsed - interval_ms;
        if (drive_cw != goal_cw || speed_goal < speed_mag) begin
          if (speed_mag >= accel_step) begin
            speed_mag = speed_mag - accel_step;
          end else begin
            // pass through zero: reflect the magnitude and take the new direction
            speed_mag = accel_step - speed_mag;
            drive_cw  = goal_cw;
            reflections++;
          end
        end else if (speed_goal > speed_mag) begin
          speed_mag = speed_mag + accel_step;
        end
      end
    endfunction

    function void note_request(in_item_t req);
      out_item_t exp;
      int        reload;
      reload = 0;
      if (req.req_type == REQ_TIMER && run_on) begin
        if (!pwm_hi) begin
          reload = int'(ticks_pct) * duty_now();
          if (ms_elapsed != {MS_W{1'b1}}) ms_elapsed++;
        end else begin
          reload = int'(ticks_pct) * (100 - duty_now());
        end
        pwm_hi = !pwm_hi;
      end else if (req.req_type == REQ_START && !run_on) begin
        goal_cw    = req.start_direction;
        drive_cw   = req.start_direction;
        speed_mag  = '0;
        speed_goal = req.speed_sample;
        ms_elapsed = '0;
        run_on     = 1'b1;
      end else if (req.req_type == REQ_CONTROL && run_on) begin
        if (req.key_code == KEY_CW) goal_cw = 1'b1;
        else if (req.key_code == KEY_CCW) goal_cw = 1'b0;
        if (req.key_code == KEY_STOP) begin
          run_on = 1'b0;
        end else begin
          speed_goal = req.speed_sample;
          ramp_speed();
        end
      end
      if (speed_mag > SPEED_FULL) clamped++;
      exp.motor_enable     = run_on;
      exp.pwm_level        = pwm_hi;
      exp.drive_clockwise  = drive_cw;
      exp.reload_ticks     = reload[RELOAD_W-1:0];
      exp.current_speed    = speed_mag;
      exp.target_speed     = speed_goal;
      exp.target_clockwise = goal_cw;
      exp.duty_percent     = DUTY_W'(duty_now());
      expected_responses.push_back(exp);
    endfunction

    function void check_response(out_item_t got);
      out_item_t exp;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("result beat with nothing pending: %h", got);
        return;
      end
      exp = expected_responses.pop_front();
      checked++;
      if (got.motor_enable !== exp.motor_enable || got.pwm_level !== exp.pwm_level ||
          got.drive_clockwise !== exp.drive_clockwise ||
          got.reload_ticks !== exp.reload_ticks || got.current_speed !== exp.current_speed ||
          got.target_speed !== exp.target_speed ||
          got.target_clockwise !== exp.target_clockwise ||
          got.duty_percent !== exp.duty_percent) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
          $display("result %0d expected en=%b pwm=%b cw=%b reload=%0d speed=%0d goal=%0d gcw=%b duty=%0d",
                   checked, exp.motor_enable, exp.pwm_level, exp.drive_clockwise, exp.reload_ticks,
                   exp.current_speed, exp.target_speed, exp.target_clockwise, exp.duty_percent);
          $display("result %0d actual   en=%b pwm=%b cw=%b reload=%0d speed=%0d goal=%0d gcw=%b duty=%0d",
                   checked, got.motor_enable, got.pwm_level, got.drive_clockwise, got.reload_ticks,
                   got.current_speed, got.target_speed, got.target_clockwise, got.duty_percent);
        end
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;

  motor_response_board   board;
  int                    send_idle_pct = 0;
  int                    stall_pct     = 0;
  int                    hold_req      = 0;
  int                    hold_seen     = 0;
  int                    hold_left     = 0;
  int                    cycles        = 0;
  int                    beats_sent    = 0;
  logic [SPEED_BITS-1:0] held_goal     = SPEED_FULL;

  ramped_bidirectional_motor_pwm dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_response(out_item);
  end

  function automatic in_item_t make_req(logic [1:0] kind, logic [1:0] key, logic cw,
                                        logic [SPEED_BITS-1:0] sample);
    in_item_t r;
    r.req_type        = kind;
    r.key_code        = key;
    r.start_direction = cw;
    r.speed_sample    = sample;
    return r;
  endfunction

  function automatic bit is_ignored(in_item_t r);
    return (r.req_type == REQ_UNUSED) || (r.req_type == REQ_START && board.run_on) ||
           ((r.req_type == REQ_TIMER || r.req_type == REQ_CONTROL) && !board.run_on);
  endfunction

  // Mostly well-formed traffic: start when stopped, then timers and control passes.
  function automatic in_item_t pick_request();
    in_item_t r;
    int       roll;
    int       pick;
    r.key_code        = 2'($urandom_range(3));
    r.start_direction = 1'($urandom_range(1));
    roll = $urandom_range(99);
    if ($urandom_range(99) < 5) held_goal = 12'($urandom_range(4095));
    pick = $urandom_range(99);
    if (pick < 70) r.speed_sample = held_goal;
    else if (pick < 80) r.speed_sample = SPEED_FULL;
    else if (pick < 85) r.speed_sample = '0;
    else r.speed_sample = 12'($urandom_range(4095));
    if (!board.run_on) begin
      if (roll < 80) r.req_type = REQ_START;
      else if (roll < 88) r.req_type = REQ_TIMER;
      else if (roll < 96) r.req_type = REQ_CONTROL;
      else r.req_type = REQ_UNUSED;
    end else if (roll < 58) begin
      r.req_type = REQ_TIMER;
    end else if (roll < 94) begin
      r.req_type = REQ_CONTROL;
      pick = $urandom_range(99);
      if (pick < 70) r.key_code = KEY_NONE;
      else if (pick < 83) r.key_code = KEY_CW;
      else if (pick < 96) r.key_code = KEY_CCW;
      else r.key_code = KEY_STOP;
    end else if (roll < 97) begin
      r.req_type = REQ_START;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // Called in the step of a rising edge; returns in the step of the accepting edge.
  task automatic send_request(input in_item_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(r);
    beats_sent++;
  endtask

  task automatic configure(input logic [ACCEL_W-1:0] accel, input logic [INTERVAL_W-1:0] iv,
                           input logic [TICKS_W-1:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACCEL_STEP;
    cfg_data  <= CFG_DATA_W'(accel);
    @(posedge clk);
    board.set_reg(REG_ACCEL_STEP, CFG_DATA_W'(accel));
    cfg_index <= REG_UPDATE_INTERVAL;
    cfg_data  <= CFG_DATA_W'(iv);
    @(posedge clk);
    board.set_reg(REG_UPDATE_INTERVAL, CFG_DATA_W'(iv));
    cfg_index <= REG_TICKS_PER_PERCENT;
    cfg_data  <= ticks;
    @(posedge clk);
    board.set_reg(REG_TICKS_PER_PERCENT, ticks);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (board.expected_responses.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic run_phase(input int beats, input logic [ACCEL_W-1:0] accel,
                           input logic [INTERVAL_W-1:0] iv, input logic [TICKS_W-1:0] ticks,
                           input int send_pct, input int stall, input bit squeeze);
    in_item_t r;
    int       done;
    done = 0;
    configure(accel, iv, ticks);
    send_idle_pct = send_pct;
    stall_pct     = stall;
    while (done < beats) begin
      r = pick_request();
      if (!is_ignored(r)) done++;
      // hold the output off while the input keeps offering, to back the block up
      if (squeeze && done == beats / 2) begin
        hold_req++;
        squeeze = 1'b0;
      end
      send_request(r);
    end
    in_valid <= 1'b0;
    drain();
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: ignored requests, duty extremes, reversal through zero, stop.
    configure(8'd200, 8'd1, 16'hFFFF);
    send_request(make_req(REQ_TIMER, KEY_NONE, 1'b1, '0));
    send_request(make_req(REQ_CONTROL, KEY_CW, 1'b1, SPEED_FULL));
    send_request(make_req(REQ_UNUSED, KEY_STOP, 1'b1, SPEED_FULL));
    send_request(make_req(REQ_START, KEY_NONE, 1'b1, SPEED_FULL));
    send_request(make_req(REQ_START, KEY_CCW, 1'b0, '0));
    repeat (4) send_request(make_req(REQ_TIMER, KEY_NONE, 1'b0, '0));
    send_request(make_req(REQ_CONTROL, KEY_NONE, 1'b0, SPEED_FULL));
    repeat (2) send_request(make_req(REQ_TIMER, KEY_STOP, 1'b1, '0));
    send_request(make_req(REQ_CONTROL, KEY_CCW, 1'b0, SPEED_FULL));
    repeat (2) send_request(make_req(REQ_TIMER, KEY_NONE, 1'b0, SPEED_FULL));
    send_request(make_req(REQ_CONTROL, KEY_NONE, 1'b1, SPEED_FULL));
    send_request(make_req(REQ_CONTROL, KEY_CW, 1'b0, '0));
    repeat (2) send_request(make_req(REQ_TIMER, KEY_NONE, 1'b0, '0));
    send_request(make_req(REQ_CONTROL, KEY_NONE, 1'b0, '0));
    repeat (2) send_request(make_req(REQ_TIMER, KEY_NONE, 1'b0, '0));
    send_request(make_req(REQ_CONTROL, KEY_CW, 1'b1, '0));
    send_request(make_req(REQ_CONTROL, KEY_STOP, 1'b0, SPEED_FULL));
    send_request(make_req(REQ_TIMER, KEY_NONE, 1'b1, SPEED_FULL));
    in_valid <= 1'b0;
    drain();

    run_phase(PHASE_BEATS, 8'd4,   8'd10,  16'd800,   0,  0,  1'b0);
    run_phase(PHASE_BEATS, 8'd255, 8'd1,   16'd1,     55, 0,  1'b0);
    run_phase(PHASE_BEATS, 8'd1,   8'd255, 16'hFFFF,  0,  55, 1'b0);
    run_phase(PHASE_BEATS, 8'd37,  8'd2,   16'd1234,  36, 36, 1'b0);
    run_phase(PHASE_BEATS, 8'd128, 8'd1,   16'd800,   0,  0,  1'b1);
    run_phase(PHASE_BEATS, 8'd3,   8'd5,   16'hFFFF,  36, 36, 1'b0);

    // Timer burst: milliseconds pile up over many low phases, so the control
    // passes after it ramp several times in a row.
    configure(8'd255, 8'd5, 16'd800);
    send_idle_pct = 0;
    stall_pct     = 0;
    if (!board.run_on) send_request(make_req(REQ_START, KEY_NONE, 1'b1, SPEED_FULL));
    repeat (BURST_BEATS) send_request(make_req(REQ_TIMER, KEY_NONE, 1'b1, SPEED_FULL));
    repeat (3) send_request(make_req(REQ_CONTROL, KEY_NONE, 1'b1, SPEED_FULL));
    send_request(make_req(REQ_CONTROL, KEY_STOP, 1'b1, SPEED_FULL));
    in_valid <= 1'b0;
    drain();
    repeat (20) @(posedge clk);

    $display("Run covered %0d request beats over directed, six random and one burst phase;",
             beats_sent);
    $display("%0d results checked, %0d mismatches, %0d zero crossings, %0d over-scale speeds",
             board.checked, board.mismatches, board.reflections, board.clamped);
    if (board.mismatches == 0 && board.expected_responses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
